### hw/rtl/rdc_pkg.sv
// Shared constants, types and the digit glyph function for the radix digit converter.
// No dependencies; every other rtl file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package rdc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // quotient bits resolved per divide cycle
  localparam int STEP_BITS = 8;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  // 'A' minus ten
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;

  typedef struct packed {
    logic load;      // take a new value, clear remainder and count
    logic step;      // one divide step
    logic store;     // write remainder to the digit store, bump count
    logic rd;        // read the digit at count-1
    logic out_load;  // move the read digit into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic count_full;
    logic count_one;
    logic out_free;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < 6'd10) begin
      digit_glyph = CHAR_ZERO + dx;
    end else begin
      digit_glyph = CHAR_LETTER + dx;
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/rdc_datapath.sv
// Datapath of the radix digit converter: radix register, multi-bit restoring divider,
// digit store memory, digit counter and output register. Uses rdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdc_datapath #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  input  wire  [rdc_pkg::RADIX_W-1:0]     cfg_radix_i,
  input  wire  [VALUE_BITS-1:0]           value_i,
  input  wire                             out_ready_i,
  output logic                            out_valid_o,
  output logic [rdc_pkg::CHAR_W-1:0]      digit_char_o,
  output logic                            last_digit_o,
  input  wire  rdc_pkg::ctrl_cmd_t        cmd_i,
  output rdc_pkg::dp_status_t             status_o
);

  localparam int SB     = rdc_pkg::STEP_BITS;
  localparam int PAD    = ((VALUE_BITS + SB - 1) / SB) * SB;
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int RW     = rdc_pkg::RADIX_W;

  logic [RW-1:0]  radix_q;
  logic [PAD-1:0] quot_q, quot_d;
  logic [RW-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]  store_mem [MAX_DIGITS];
  logic [RW-1:0]  rdata_q;
  logic           out_valid_q;
  logic [rdc_pkg::CHAR_W-1:0] char_q;
  logic           last_q;

  logic [SB-1:0]  qbits;
  logic [SB-1:0]  qtop;
  logic [RW:0]    acc;
  logic [CNT_W-1:0] cnt_dec;

  assign qtop    = quot_q[PAD-1 -: SB];
  assign cnt_dec = cnt_q - CNT_W'(1);

  // restoring division of the top bits by the radix, one bit per inner iteration
  always_comb begin
    acc   = {1'b0, rem_q};
    qbits = '0;
    for (int i = SB - 1; i >= 0; i--) begin
      acc = {acc[RW-1:0], qtop[i]};
      if (acc >= {1'b0, radix_q}) begin
        acc      = acc - {1'b0, radix_q};
        qbits[i] = 1'b1;
      end
    end
    quot_d = (quot_q << SB) | PAD'(qbits);
    rem_d  = acc[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= rdc_pkg::RADIX_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_radix_i < rdc_pkg::RADIX_MIN) begin
          radix_q <= rdc_pkg::RADIX_MIN;
        end else if (cfg_radix_i > rdc_pkg::RADIX_MAX) begin
          radix_q <= rdc_pkg::RADIX_MAX;
        end else begin
          radix_q <= cfg_radix_i;
        end
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.store) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.out_load) begin
        cnt_q <= cnt_dec;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quot_q <= PAD'(value_i);
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end else if (cmd_i.store) begin
      rem_q <= '0;
    end
    if (cmd_i.store) begin
      store_mem[cnt_q[IDX_W-1:0]] <= rem_q;
    end
    if (cmd_i.rd) begin
      rdata_q <= store_mem[cnt_dec[IDX_W-1:0]];
    end
    if (cmd_i.out_load) begin
      char_q <= rdc_pkg::digit_glyph(rdata_q);
      last_q <= (cnt_q == CNT_W'(1));
    end
  end

  assign status_o.quot_zero  = (quot_q == '0);
  assign status_o.count_full = (cnt_q == CNT_W'(MAX_DIGITS - 1));
  assign status_o.count_one  = (cnt_q == CNT_W'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule
`default_nettype wire

### hw/rtl/rdc_ctrl.sv
// Controller of the radix digit converter: sequences load, divide, store and digit
// playback. Talks to rdc_datapath through rdc_pkg command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module rdc_ctrl #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  output rdc_pkg::ctrl_cmd_t       cmd_o,
  input  wire  rdc_pkg::dp_status_t status_i
);

  localparam int SB    = rdc_pkg::STEP_BITS;
  localparam int STEPS = (VALUE_BITS + SB - 1) / SB;
  localparam int SC_W  = $clog2(STEPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_RD,
    ST_OUT
  } state_e;

  state_e state_q;
  logic [SC_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DIV;
            step_q  <= SC_W'(STEPS - 1);
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_STORE;
          end else begin
            step_q <= step_q - SC_W'(1);
          end
        end
        ST_STORE: begin
          // a zero value still yields one digit, the remainder zero
          if (status_i.quot_zero || status_i.count_full) begin
            state_q <= ST_RD;
          end else begin
            state_q <= ST_DIV;
            step_q  <= SC_W'(STEPS - 1);
          end
        end
        ST_RD: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (status_i.out_free) begin
            state_q <= status_i.count_one ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step     = (state_q == ST_DIV);
    cmd_o.store    = (state_q == ST_STORE);
    cmd_o.rd       = (state_q == ST_RD);
    cmd_o.out_load = (state_q == ST_OUT) && status_i.out_free;
  end

endmodule
`default_nettype wire

### hw/rtl/radix_digit_converter_unit.sv
// Top level of the radix digit converter: joins rdc_ctrl and rdc_datapath.
// Depends on rdc_pkg, rdc_ctrl and rdc_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Converts each input item (an unsigned value) to its digit text in the radix held in
// the configuration register (2..36, reset 10; writes outside that range saturate) and
// emits one output item per digit, most significant first, as ASCII '0'-'9'/'A'-'Z',
// with last_digit_o set on the final digit. Zero gives the single digit '0'. The
// divider resolves STEP_BITS (8) quotient bits per cycle; a digit is extracted by
// divide steps over the whole value, then its remainder is written to the digit store
// memory, and playback reads each digit back (registered read, then output load,
// which waits while the output is stalled). The next item is accepted as soon as
// the last digit sits in the output register. The configuration port is always ready.
module radix_digit_converter_unit #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [rdc_pkg::RADIX_W-1:0]  cfg_radix_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [VALUE_BITS-1:0]        value_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [rdc_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_digit_o
);

  rdc_pkg::ctrl_cmd_t  cmd;
  rdc_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rdc_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  rdc_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_radix_i  (cfg_radix_i),
    .value_i      (value_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for radix_digit_converter_unit: a directed table, then random phases.
// Depends on rdc_pkg and the radix_digit_converter_unit rtl; it reads no files.
`timescale 1ns / 1ps
module testbench;

  localparam int          DIRECTED_ROWS   = 25;
  localparam int          RANDOM_PHASES   = 10;
  localparam int          ITEMS_PER_PHASE = 39;
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;

  typedef enum bit {ROW_VALUE, ROW_RADIX} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] data;
    string       want;  // empty: predicted digits
  } dir_row_t;

  typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [rdc_pkg::RADIX_W-1:0] cfg_radix_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [31:0]                 value_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [rdc_pkg::CHAR_W-1:0]  digit_char_o;
  logic                        last_digit_o;

  digit_t                      digits_due[$];
  logic [rdc_pkg::RADIX_W-1:0] held_radix;
  int                          errors;
  int                          values_sent;
  int                          digits_checked;
  int unsigned                 cycle_count;
  bit                          tx_no_gaps;
  bit                          rx_always_ready;
  int                          rx_hold;

  dir_row_t directed [DIRECTED_ROWS] = '{
    '{ROW_VALUE, 32'h0000_0000, "0"},
    '{ROW_VALUE, 32'hFFFF_FFFF, "4294967295"},
    '{ROW_VALUE, 32'h0000_0001, "1"},
    '{ROW_RADIX, 32'd0,         ""},
    '{ROW_VALUE, 32'hFFFF_FFFF, "11111111111111111111111111111111"},
    '{ROW_VALUE, 32'h8000_0000, ""},
    '{ROW_RADIX, 32'd1,         ""},
    '{ROW_VALUE, 32'h0000_0000, "0"},
    '{ROW_VALUE, 32'h0000_0005, "101"},
    '{ROW_RADIX, 32'd63,        ""},
    '{ROW_VALUE, 32'hFFFF_FFFF, "1Z141Z3"},
    '{ROW_RADIX, 32'd37,        ""},
    '{ROW_VALUE, 32'd35,        "Z"},
    '{ROW_VALUE, 32'd36,        "10"},
    '{ROW_RADIX, 32'd16,        ""},
    '{ROW_VALUE, 32'hDEAD_BEEF, "DEADBEEF"},
    '{ROW_VALUE, 32'h0000_000A, "A"},
    '{ROW_RADIX, 32'd8,         ""},
    '{ROW_VALUE, 32'hFFFF_FFFF, "37777777777"},
    '{ROW_RADIX, 32'd3,         ""},
    '{ROW_VALUE, 32'h1234_5678, ""},
    '{ROW_RADIX, 32'd10,        ""},
    '{ROW_VALUE, 32'd9,         "9"},
    '{ROW_VALUE, 32'd10,        "10"},
    '{ROW_VALUE, 32'h7FFF_FFFF, "2147483647"}
  };

  radix_digit_converter_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_radix_i  (cfg_radix_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d digits still due", $time, digits_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // divide repeatedly, then emit remainders most significant first
  function automatic void predict_digits(input logic [31:0] v);
    logic [rdc_pkg::RADIX_W-1:0] rems[$];
    logic [rdc_pkg::RADIX_W-1:0] rem;
    logic [31:0]                 quot;
    digit_t                      d;
    quot = v;
    do begin
      rem  = rdc_pkg::RADIX_W'(quot % 32'(held_radix));
      rems = {rems, rem};
      quot = quot / 32'(held_radix);
    end while (quot != 0);
    while (rems.size() != 0) begin
      rem        = rems.pop_back();
      d.ch       = (rem < 6'd10) ? rdc_pkg::CHAR_ZERO + 7'(rem) : rdc_pkg::CHAR_LETTER + 7'(rem);
      d.last     = (rems.size() == 0);
      digits_due = {digits_due, d};
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_no_gaps || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic send_value(input logic [31:0] v, input int gap, input string want);
    digit_t d;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    values_sent++;
    if (want.len() == 0) begin
      predict_digits(v);
    end else begin
      for (int i = 0; i < want.len(); i++) begin
        d.ch       = 7'(want[i]);
        d.last     = (i == want.len() - 1);
        digits_due = {digits_due, d};
      end
    end
  endtask

  // sender holds off until every due digit has been taken
  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [rdc_pkg::RADIX_W-1:0] r);
    drain_outputs();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (r < rdc_pkg::RADIX_MIN) begin
      held_radix = rdc_pkg::RADIX_MIN;
    end else if (r > rdc_pkg::RADIX_MAX) begin
      held_radix = rdc_pkg::RADIX_MAX;
    end else begin
      held_radix = r;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: runs of ready, short stalls and a few long ones
  always @(negedge clk_i) begin
    if (rx_always_ready) begin
      out_ready_i <= 1'b1;
      rx_hold = 0;
    end else if (rx_hold == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_ready_i <= 1'b1;
          rx_hold = $urandom_range(1, 20);
        end
        9: begin
          out_ready_i <= 1'b0;
          rx_hold = $urandom_range(10, 40);
        end
        default: begin
          out_ready_i <= 1'b0;
          rx_hold = $urandom_range(1, 3);
        end
      endcase
    end else begin
      rx_hold--;
    end
  end

  always @(posedge clk_i) begin : check_digit
    digit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digits_due.size() == 0) begin
        $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                 $time, digit_char_o, last_digit_o);
        errors++;
      end else begin
        want = digits_due.pop_front();
        digits_checked++;
        if (digit_char_o !== want.ch) begin
          $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                   $time, want.ch, digit_char_o);
          errors++;
        end
        if (last_digit_o !== want.last) begin
          $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                   $time, want.last, last_digit_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0]     v;
    longint unsigned pw;
    int              n;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_radix_i     = '0;
    in_valid_i      = 1'b0;
    value_i         = '0;
    out_ready_i     = 1'b0;
    held_radix      = rdc_pkg::RADIX_RESET;
    errors          = 0;
    values_sent     = 0;
    digits_checked  = 0;
    cycle_count     = 0;
    tx_no_gaps      = 1'b0;
    rx_always_ready = 1'b0;
    rx_hold         = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_RADIX) begin
        write_radix(directed[i].data[rdc_pkg::RADIX_W-1:0]);
      end else begin
        send_value(directed[i].data, pick_gap(), directed[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // first two phases sit on the range limits
      if (ph == 0) begin
        write_radix(rdc_pkg::RADIX_MIN);
      end else if (ph == 1) begin
        write_radix(rdc_pkg::RADIX_MAX);
      end else begin
        write_radix(rdc_pkg::RADIX_W'($urandom_range(0, 63)));
      end
      tx_no_gaps      = (ph == 3);
      rx_always_ready = (ph == 4);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ($urandom_range(0, 9))
          0: v = '0;
          1: v = '1;
          2: begin
            // a power of the radix or one below it
            pw = 1;
            n  = $urandom_range(1, 32);
            repeat (n) begin
              if (pw * held_radix <= 64'hFFFF_FFFF) pw = pw * held_radix;
            end
            v = 32'(pw - $urandom_range(0, 1));
          end
          3, 4, 5: v = $urandom >> $urandom_range(0, 31);
          default: v = $urandom;
        endcase
        send_value(v, pick_gap(), "");
      end
    end

    drain_outputs();
    repeat (20) @(posedge clk_i);
    $display("converted %0d values, %0d digits checked, radix writes from 0 to 63",
             values_sent, digits_checked);
    $display("covering saturation at both ends and idle phases on either side");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_datapath.sv
hw/rtl/rdc_ctrl.sv
hw/rtl/radix_digit_converter_unit.sv
bench/testbench.sv
